// ----- hdl/ecu_pkg.sv -----
// ----------------------------------------------------------------------------
// ecu_pkg: shared constants, types and lookup tables for the easing curve unit
// Q1.15 formats, curve codes, pipeline stage words and the Q1.30 exp2 and
// quarter-wave sine tables, built at elaboration from integer series.
// ----------------------------------------------------------------------------
package ecu_pkg;

    localparam int FRAC_BITS       = 15;
    localparam int TABLE_ADDR_BITS = 8;
    localparam int TAB_N           = 1 << TABLE_ADDR_BITS;
    localparam int TAB_HALF        = TAB_N / 2;
    localparam int IDX_LO          = FRAC_BITS - TABLE_ADDR_BITS;

    localparam logic [15:0] ONE_Q  = 16'd32768;
    localparam logic [15:0] HALF_Q = 16'd16384;
    localparam logic [63:0] Q30    = 64'd1 << 30;

    // curve codes
    localparam logic [3:0] M_LINEAR      = 4'd0;
    localparam logic [3:0] M_QUAD_IN     = 4'd1;
    localparam logic [3:0] M_QUAD_OUT    = 4'd2;
    localparam logic [3:0] M_QUAD_INOUT  = 4'd3;
    localparam logic [3:0] M_CUBIC_IN    = 4'd4;
    localparam logic [3:0] M_CUBIC_OUT   = 4'd5;
    localparam logic [3:0] M_CUBIC_INOUT = 4'd6;
    localparam logic [3:0] M_QUART_IN    = 4'd7;
    localparam logic [3:0] M_QUART_OUT   = 4'd8;
    localparam logic [3:0] M_QUART_INOUT = 4'd9;
    localparam logic [3:0] M_EXPO_IN     = 4'd10;
    localparam logic [3:0] M_EXPO_OUT    = 4'd11;
    localparam logic [3:0] M_EXPO_INOUT  = 4'd12;
    localparam logic [3:0] M_SINE_IN     = 4'd13;
    localparam logic [3:0] M_SINE_OUT    = 4'd14;
    localparam logic [3:0] M_SINE_INOUT  = 4'd15;

    typedef logic [30:0] lut_word_t;
    typedef lut_word_t tab_t [0:TAB_N];

    typedef struct packed {
        logic [3:0]  mode;
        logic [15:0] t;      // saturated progress
        logic [3:0]  k;      // exp2 integer shift
    } ecu_ctl_t;

    typedef struct packed {
        ecu_ctl_t    ctl;
        logic [15:0] x;      // polynomial operand (t or 1-t)
        logic [15:0] f;      // table argument
    } ecu_prep_t;

    typedef struct packed {
        ecu_ctl_t    ctl;
        logic [15:0] poly;   // x^2, x^3 or x^4 by curve family
        lut_word_t   lut;    // interpolated table value, Q1.30
    } ecu_core_t;

    function automatic logic [63:0] mul30(input logic [63:0] a, input logic [63:0] b);
        return (a * b + (Q30 >> 1)) >> 30;
    endfunction

    // elaboration only: truncating long division for the series coefficients
    function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] rem;
        q   = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[63:0], num[b]};
            if (rem >= 65'(den))
            begin
                rem  = rem - 65'(den);
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [63:0] sin_div(input int i);
        logic [63:0] d;
        case (i)
            0:       d = 64'd210;
            1:       d = 64'd156;
            2:       d = 64'd110;
            3:       d = 64'd72;
            4:       d = 64'd42;
            5:       d = 64'd20;
            default: d = 64'd6;
        endcase
        return d;
    endfunction

    // elaboration only: Horner-form series for 2^(-j/N) and sin(j/N * pi/2)
    function automatic tab_t build_tab(input logic sine);
        tab_t        tab;
        logic [63:0] j64;
        logic [63:0] z;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        for (int j = 0; j <= TAB_N; j++)
        begin
            j64 = 64'(j);
            z = (64'd744261118 * j64 + 64'(TAB_HALF)) >> TABLE_ADDR_BITS;
            x = (64'd1686629713 * j64 + 64'(TAB_HALF)) >> TABLE_ADDR_BITS;
            term = Q30;
            if (!sine)
            begin
                for (int k = 12; k >= 1; k--)
                    term = Q30 - div_u64(mul30(z, term), 64'(k));
            end
            else
            begin
                x2 = mul30(x, x);
                for (int i = 0; i < 7; i++)
                    term = Q30 - div_u64(mul30(x2, term), sin_div(i));
                term = mul30(x, term);
                if (term > Q30)
                    term = Q30;
            end
            tab[j] = term[30:0];
        end
        return tab;
    endfunction

    localparam tab_t EXP_TAB = build_tab(1'b0);
    localparam tab_t SIN_TAB = build_tab(1'b1);

endpackage

// ----- hdl/ecu_prep.sv -----
// ----------------------------------------------------------------------------
// ecu_prep: front stage
// Saturates progress, picks the polynomial operand, forms the exp2 exponent
// and the table argument for the expo and sine curves.
// ----------------------------------------------------------------------------
module ecu_prep
    import ecu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [3:0]  in_mode,
    input  logic [15:0] in_progress,
    output logic        out_valid,
    input  logic        out_ready,
    output ecu_prep_t   out_data
);

    logic        valid_reg;
    ecu_prep_t   data_reg;
    ecu_prep_t   data_next;
    logic        en;
    logic [15:0] t;
    logic [15:0] u;
    logic        lower;
    logic [19:0] n;
    logic        extra;

    assign en       = !valid_reg || out_ready;
    assign in_ready = en;

    always_comb
    begin
        t     = (in_progress > ONE_Q) ? ONE_Q : in_progress;
        u     = ONE_Q - t;
        lower = t < HALF_Q;
        extra = 1'b0;
        case (in_mode)
            M_EXPO_IN:    n = 20'(u) * 20'd10;
            M_EXPO_OUT:   n = 20'(t) * 20'd10;
            M_EXPO_INOUT:
            begin
                extra = 1'b1;
                n = lower ? (20'(ONE_Q) * 20'd10 - 20'(t) * 20'd20)
                          : (20'(t) * 20'd20 - 20'(ONE_Q) * 20'd10);
            end
            default:      n = '0;
        endcase

        data_next.ctl.mode = in_mode;
        data_next.ctl.t    = t;
        data_next.ctl.k    = 4'(n[19:FRAC_BITS]) + 4'(extra);

        case (in_mode)
            M_QUAD_IN, M_CUBIC_IN, M_QUART_IN:    data_next.x = t;
            M_QUAD_OUT, M_CUBIC_OUT, M_QUART_OUT: data_next.x = u;
            M_QUAD_INOUT, M_CUBIC_INOUT, M_QUART_INOUT:
                data_next.x = lower ? t : u;
            default:                              data_next.x = t;
        endcase

        case (in_mode)
            M_SINE_IN:    data_next.f = u;
            M_SINE_OUT:   data_next.f = t;
            M_SINE_INOUT: data_next.f = (t <= HALF_Q) ? 16'(ONE_Q - (t << 1))
                                                      : 16'((t << 1) - ONE_Q);
            default:      data_next.f = {1'b0, n[FRAC_BITS-1:0]};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en && in_valid)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ----- hdl/ecu_core.sv -----
// ----------------------------------------------------------------------------
// ecu_core: two multiply stages
// Stage A squares the operand and reads the table pair. Stage B forms x^3
// and x^4 and interpolates between the table entries.
// ----------------------------------------------------------------------------
module ecu_core
    import ecu_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  ecu_prep_t in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output ecu_core_t out_data
);

    typedef struct packed {
        ecu_ctl_t    ctl;
        logic [15:0] x;
        logic [15:0] sq;
        lut_word_t   a;
        lut_word_t   b;
        logic [14:0] rem;
    } stage_a_t;

    logic      va_reg;
    logic      vb_reg;
    stage_a_t  a_reg;
    stage_a_t  a_next;
    ecu_core_t b_reg;
    ecu_core_t b_next;
    logic      en_a;
    logic      en_b;

    logic [TABLE_ADDR_BITS:0] idx;
    logic [TABLE_ADDR_BITS:0] idx_hi;
    logic                     is_sine;
    lut_word_t                diff;
    logic [45:0]              prod;
    lut_word_t                delta;
    logic [15:0]              cube;
    logic [15:0]              q4;

    function automatic logic [15:0] mulq(input logic [15:0] p, input logic [15:0] q);
        logic [32:0] w;
        w = 33'(p) * 33'(q) + 33'(HALF_Q);
        return w[30:15];
    endfunction

    assign en_b     = !vb_reg || out_ready;
    assign en_a     = !va_reg || en_b;
    assign in_ready = en_a;

    always_comb
    begin
        idx     = in_data.f[FRAC_BITS:IDX_LO];
        idx_hi  = (idx == (TABLE_ADDR_BITS+1)'(TAB_N)) ? idx : idx + 1'b1;
        is_sine = (in_data.ctl.mode == M_SINE_IN) || (in_data.ctl.mode == M_SINE_OUT) ||
                  (in_data.ctl.mode == M_SINE_INOUT);
        a_next.ctl = in_data.ctl;
        a_next.x   = in_data.x;
        a_next.sq  = mulq(in_data.x, in_data.x);
        a_next.a   = is_sine ? SIN_TAB[idx] : EXP_TAB[idx];
        a_next.b   = is_sine ? SIN_TAB[idx_hi] : EXP_TAB[idx_hi];
        a_next.rem = {in_data.f[IDX_LO-1:0], {TABLE_ADDR_BITS{1'b0}}};
    end

    always_comb
    begin
        cube  = mulq(a_reg.sq, a_reg.x);
        q4    = mulq(a_reg.sq, a_reg.sq);
        diff  = (a_reg.b >= a_reg.a) ? a_reg.b - a_reg.a : a_reg.a - a_reg.b;
        prod  = 46'(diff) * 46'(a_reg.rem) + 46'(HALF_Q);
        delta = prod[45:FRAC_BITS];
        b_next.ctl = a_reg.ctl;
        b_next.lut = (a_reg.b >= a_reg.a) ? a_reg.a + delta : a_reg.a - delta;
        case (a_reg.ctl.mode)
            M_CUBIC_IN, M_CUBIC_OUT, M_CUBIC_INOUT: b_next.poly = cube;
            M_QUART_IN, M_QUART_OUT, M_QUART_INOUT: b_next.poly = q4;
            default:                                b_next.poly = a_reg.sq;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else
        begin
            if (en_a)
                va_reg <= in_valid;
            if (en_b)
                vb_reg <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_a && in_valid)
            a_reg <= a_next;
        if (en_b && va_reg)
            b_reg <= b_next;
    end

    assign out_valid = vb_reg;
    assign out_data  = b_reg;

endmodule

// ----- hdl/ecu_post.sv -----
// ----------------------------------------------------------------------------
// ecu_post: output stage
// Applies in/out/in-out folding, the exp2 shift, sine offsets and the final
// clamp to 1.0, then holds the word for the downstream side.
// ----------------------------------------------------------------------------
module ecu_post
    import ecu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  ecu_core_t   in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] out_value
);

    logic        valid_reg;
    logic [15:0] value_reg;
    logic [15:0] value_next;
    logic        en;
    logic [3:0]  mode;
    logic [15:0] t;
    logic        lower;
    logic [19:0] sp;
    logic [19:0] pe;
    logic [19:0] r;

    // 1.0 - v; a negative difference ends up clamped to 1.0
    function automatic logic [19:0] one_minus(input logic [19:0] v);
        return (v > 20'(ONE_Q)) ? 20'(ONE_Q) : 20'(ONE_Q) - v;
    endfunction

    function automatic logic [19:0] from30(input logic [31:0] v, input logic [4:0] s);
        logic [32:0] w;
        w = 33'(v) + (33'd1 << (s - 5'd1));
        return 20'(w >> s);
    endfunction

    assign en       = !valid_reg || out_ready;
    assign in_ready = en;

    always_comb
    begin
        mode  = in_data.ctl.mode;
        t     = in_data.ctl.t;
        lower = t < HALF_Q;
        case (mode)
            M_QUAD_INOUT:  sp = 20'(in_data.poly) << 1;
            M_CUBIC_INOUT: sp = 20'(in_data.poly) << 2;
            default:       sp = 20'(in_data.poly) << 3;
        endcase
        pe = from30(32'(in_data.lut), 5'(FRAC_BITS) + 5'(in_data.ctl.k));
        case (mode)
            M_LINEAR:                             r = 20'(t);
            M_QUAD_IN, M_CUBIC_IN, M_QUART_IN:    r = 20'(in_data.poly);
            M_QUAD_OUT, M_CUBIC_OUT, M_QUART_OUT: r = one_minus(20'(in_data.poly));
            M_QUAD_INOUT, M_CUBIC_INOUT, M_QUART_INOUT:
                r = lower ? sp : one_minus(sp);
            M_EXPO_IN:  r = (t == 16'd0) ? 20'd0 : pe;
            M_EXPO_OUT: r = (t == ONE_Q) ? 20'(ONE_Q) : one_minus(pe);
            M_EXPO_INOUT:
            begin
                if (t == 16'd0)
                    r = 20'd0;
                else if (t == ONE_Q)
                    r = 20'(ONE_Q);
                else
                    r = lower ? pe : one_minus(pe);
            end
            M_SINE_IN:  r = one_minus(from30(32'(in_data.lut), 5'(FRAC_BITS)));
            M_SINE_OUT: r = from30(32'(in_data.lut), 5'(FRAC_BITS));
            M_SINE_INOUT:
                r = (t <= HALF_Q)
                    ? from30(32'(Q30) - 32'(in_data.lut), 5'(FRAC_BITS + 1))
                    : from30(32'(Q30) + 32'(in_data.lut), 5'(FRAC_BITS + 1));
            default:    r = 20'(t);
        endcase
        value_next = (r > 20'(ONE_Q)) ? ONE_Q : r[15:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en && in_valid)
            value_reg <= value_next;
    end

    assign out_valid = valid_reg;
    assign out_value = value_reg;

endmodule

// ----- hdl/easing_curve_unit.sv -----
// ----------------------------------------------------------------------------
// easing_curve_unit: Q1.15 easing curve evaluator
// Linear, quad, cubic, quart, expo and sine curves in in/out/in-out forms.
//
//   channel   dir   payload
//   s_axis    in    tdata[3:0] easing_mode, tdata[19:4] progress
//   m_axis    out   tdata[15:0] eased_value
//
// One word per clock while m_axis_tready is high; the registered stages are
// front, square and table read, cube/quart and interpolation, output register.
// Each stage has its own valid bit and advances when empty or when the next
// stage moves, so bubbles close up under back-pressure and nothing is lost.
// Reset clears the valid bits only.
// ----------------------------------------------------------------------------
module easing_curve_unit
    import ecu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [3:0] easing_mode, [19:4] progress
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // [15:0] eased_value
);

    logic      prep_valid;
    logic      prep_ready;
    ecu_prep_t prep_data;
    logic      core_valid;
    logic      core_ready;
    ecu_core_t core_data;

    ecu_prep u_prep (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_mode     (s_axis_tdata[3:0]),
        .in_progress (s_axis_tdata[19:4]),
        .out_valid   (prep_valid),
        .out_ready   (prep_ready),
        .out_data    (prep_data)
    );

    ecu_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (prep_valid),
        .in_ready  (prep_ready),
        .in_data   (prep_data),
        .out_valid (core_valid),
        .out_ready (core_ready),
        .out_data  (core_data)
    );

    ecu_post u_post (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (core_valid),
        .in_ready  (core_ready),
        .in_data   (core_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_value (m_axis_tdata)
    );

    // result never exceeds 1.0
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata <= ONE_Q))
        else $error("eased value above 1.0");

    // with the output side open the whole pipe moves
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input stalled while output is ready");

    // an empty output stage fills only from the stage before it
    assert property (@(posedge clk) disable iff (!rst_n)
        (!m_axis_tvalid && !core_valid) |=> !m_axis_tvalid)
        else $error("word appeared without passing the pipeline");

endmodule
